/* hw/rtl/scpa_pkg.sv */
// ----------------------------------------------------------------------------
// scpa_pkg
// Shared types and constants of the size-class pool allocator.
// ----------------------------------------------------------------------------
package scpa_pkg;

  localparam int POOL_BYTES      = 4096;
  localparam int ALIGN_BYTES     = 8;
  localparam int HEADER_BYTES    = 16;
  localparam int MAX_CLASS_BYTES = 256;
  localparam int CLASS_LIMIT     = 4;
  localparam int NREG            = 4;
  localparam int NCLS            = (CLASS_LIMIT < NREG) ? CLASS_LIMIT : NREG;
  localparam int GRANULES        = POOL_BYTES / ALIGN_BYTES;
  localparam int GRAN_W          = $clog2(GRANULES);
  localparam int ALIGN_SH        = $clog2(ALIGN_BYTES);
  localparam int POOL_SH         = $clog2(POOL_BYTES);
  localparam int HDR_W           = 3 + GRAN_W + 1;
  localparam int PCT_FULL        = 100;
  localparam int USED_MAX        = 8191;
  localparam logic [2:0] TAG_NONE = 3'd7;

  localparam logic [1:0] FN_ALLOC = 2'd0;
  localparam logic [1:0] FN_FREE  = 2'd1;
  localparam logic [1:0] FN_CARVE = 2'd2;
  localparam logic [1:0] FN_RSVD  = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BIG     = 3'd1;
  localparam logic [2:0] ST_NOCLS   = 3'd2;
  localparam logic [2:0] ST_OOM     = 3'd3;
  localparam logic [2:0] ST_NULL    = 3'd4;
  localparam logic [2:0] ST_INVALID = 3'd5;
  localparam logic [2:0] ST_CORRUPT = 3'd6;
  localparam logic [2:0] ST_SHARES  = 3'd7;

  typedef struct packed {
    logic [1:0]  func;
    logic [11:0] req_bytes;
    logic [11:0] user_offset;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] block_offset;
    logic [1:0]  class_used;
    logic [12:0] used_bytes;
  } out_item_t;

  typedef enum logic [2:0] {
    S_INIT_CLR, S_IDLE, S_DEC, S_MEM, S_CARVE_CLR, S_CARVE, S_RESP
  } state_t;

  typedef struct packed {
    logic load_in;
    logic dec;
    logic carve_init;
    logic clr_step;
    logic commit;
    logic carve_step;
    logic resp;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic dec_mem;
    logic dec_carve;
    logic carve_done;
    logic out_free;
  } sts_t;

endpackage

/* hw/rtl/scpa_ctrl.sv */
// ----------------------------------------------------------------------------
// scpa_ctrl
// Sequencer: clearing pass, decode, header access, carve walk, response.
// ----------------------------------------------------------------------------
module scpa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  scpa_pkg::sts_t sts,
  output scpa_pkg::cmd_t cmd,
  output logic          in_ready
);
  import scpa_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT_CLR:  if (sts.clr_last) state_nxt = S_IDLE;
      S_IDLE:      if (in_fire) state_nxt = S_DEC;
      S_DEC: begin
        if (sts.dec_carve) state_nxt = S_CARVE_CLR;
        else if (sts.dec_mem) state_nxt = S_MEM;
        else state_nxt = S_RESP;
      end
      S_MEM:       state_nxt = S_RESP;
      S_CARVE_CLR: if (sts.clr_last) state_nxt = S_CARVE;
      S_CARVE:     if (sts.carve_done) state_nxt = S_RESP;
      S_RESP:      if (sts.out_free) state_nxt = S_IDLE;
      default:     state_nxt = S_INIT_CLR;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.load_in    = (state_r == S_IDLE) && in_fire;
    cmd.dec        = (state_r == S_DEC);
    cmd.carve_init = (state_r == S_DEC) && sts.dec_carve;
    cmd.clr_step   = (state_r == S_INIT_CLR) || (state_r == S_CARVE_CLR);
    cmd.commit     = (state_r == S_MEM);
    cmd.carve_step = (state_r == S_CARVE);
    cmd.resp       = (state_r == S_RESP) && sts.out_free;
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

/* hw/rtl/scpa_dp.sv */
// ----------------------------------------------------------------------------
// scpa_dp
// Datapath: header memory, free-list heads, used counter, carve walk and
// result register.
// ----------------------------------------------------------------------------
module scpa_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  scpa_pkg::cmd_t         cmd,
  output scpa_pkg::sts_t         sts,
  input  scpa_pkg::in_item_t     in_data,
  input  logic [3:0][8:0]        class_bytes,
  input  logic [3:0][6:0]        share_pct,
  output logic                   out_valid,
  input  logic                   out_ready,
  output scpa_pkg::out_item_t    out_data
);
  import scpa_pkg::*;

  logic [HDR_W-1:0]  hdr_mem [GRANULES];
  logic [HDR_W-1:0]  rdata_r;
  logic [GRAN_W-1:0] head_r [NREG];
  logic [NREG-1:0]   head_ok_r;
  logic [GRAN_W-1:0] clr_idx_r;
  logic [12:0]       used_r;
  in_item_t          in_r;
  logic [2:0]        res_status_r;
  logic [11:0]       res_off_r;
  logic [1:0]        res_cls_r;
  logic [GRAN_W-1:0] g_r;
  logic [1:0]        k_r;
  logic [12:0]       aligned_r;
  logic [2:0]        ck_r;
  logic [12:0]       ptr_r;
  logic [12:0]       cc_r;
  logic [9:0]        hdrs_r;
  logic              out_valid_r;
  out_item_t         out_r;

  logic [2:0]        n_act;
  logic [12:0]       aligned;
  logic              too_big;
  logic              fit_found;
  logic [1:0]        kfit;
  logic [8:0]        psum;
  logic [11:0]       boff;
  logic [2:0]        dec_status;
  logic              dec_mem;
  logic              dec_carve;
  logic [1:0]        hd_idx;
  logic [GRAN_W-1:0] hd_g;
  logic              hd_ok;
  logic [2:0]        tag;
  logic [1:0]        ck;
  logic [10:0]       stride;
  logic [13:0]       cy;
  logic [20:0]       prod;
  logic [18:0]       lim;
  logic [13:0]       pend;
  logic              fits;
  logic              carve_done;
  logic [GRAN_W-1:0] rd_addr;
  logic              we;
  logic [GRAN_W-1:0] waddr;
  logic [HDR_W-1:0]  wdata;
  logic [13:0]       used_add;
  logic [13:0]       hdr_bytes;
  logic [8:0]        cb_free;

  always_comb begin
    n_act = 3'(NCLS);
    for (int i = NCLS - 1; i >= 0; i--) begin
      if (class_bytes[i] == 9'd0) n_act = 3'(i);
    end
  end

  always_comb begin
    aligned   = (13'(in_r.req_bytes) + 13'(ALIGN_BYTES - 1)) &
                ~13'(ALIGN_BYTES - 1);
    too_big   = (aligned == 13'd0) || (aligned > 13'(MAX_CLASS_BYTES));
    fit_found = 1'b0;
    kfit      = '0;
    for (int i = NCLS - 1; i >= 0; i--) begin
      if ((3'(i) < n_act) && (13'(class_bytes[i]) >= aligned)) begin
        fit_found = 1'b1;
        kfit      = 2'(i);
      end
    end
    psum = '0;
    for (int i = 0; i < NCLS; i++) begin
      if (3'(i) < n_act) psum = psum + 9'(share_pct[i]);
    end
    boff = in_r.user_offset - 12'(HEADER_BYTES);
  end

  always_comb begin
    dec_status = ST_OK;
    dec_mem    = 1'b0;
    dec_carve  = 1'b0;
    unique case (in_r.func)
      FN_ALLOC: begin
        if (too_big) dec_status = ST_BIG;
        else if (!fit_found) dec_status = ST_NOCLS;
        else if (!head_ok_r[kfit]) dec_status = ST_OOM;
        else dec_mem = 1'b1;
      end
      FN_FREE: begin
        if (in_r.user_offset == 12'd0) dec_status = ST_NULL;
        else if (in_r.user_offset < 12'(HEADER_BYTES)) dec_status = ST_INVALID;
        else if (boff[ALIGN_SH-1:0] != '0) dec_status = ST_CORRUPT;
        else dec_mem = 1'b1;
      end
      FN_CARVE: begin
        if (psum != 9'(PCT_FULL)) dec_status = ST_SHARES;
        else dec_carve = 1'b1;
      end
      default: dec_status = ST_INVALID;
    endcase
  end

  assign tag = rdata_r[HDR_W-1 -: 3];
  assign ck  = ck_r[1:0];

  always_comb begin
    priority if (cmd.carve_step) hd_idx = ck;
    else if (cmd.commit && (in_r.func == FN_FREE)) hd_idx = tag[1:0];
    else hd_idx = kfit;
  end
  assign hd_g  = head_r[hd_idx];
  assign hd_ok = head_ok_r[hd_idx];

  always_comb begin
    stride = (11'(HEADER_BYTES) + 11'(class_bytes[ck]) + 11'(ALIGN_BYTES - 1)) &
             ~11'(ALIGN_BYTES - 1);
    cy     = 14'(cc_r) + 14'(stride);
    prod   = 21'(cy) * 21'(PCT_FULL);
    lim    = 19'(share_pct[ck]) << POOL_SH;
    pend   = 14'(ptr_r) + 14'(stride);
    fits   = (prod <= 21'(lim)) && (pend <= 14'(POOL_BYTES));
    carve_done = (ck_r >= n_act);
  end

  assign rd_addr = (in_r.func == FN_ALLOC) ? hd_g : boff[ALIGN_SH +: GRAN_W];

  always_comb begin
    we    = 1'b0;
    waddr = clr_idx_r;
    wdata = {TAG_NONE, {(HDR_W-3){1'b0}}};
    priority if (cmd.clr_step) begin
      we = 1'b1;
    end else if (cmd.carve_step && !carve_done && fits) begin
      we    = 1'b1;
      waddr = ptr_r[ALIGN_SH +: GRAN_W];
      wdata = {ck_r, hd_g, hd_ok};
    end else if (cmd.commit && (in_r.func == FN_FREE) && (tag < n_act)) begin
      we    = 1'b1;
      waddr = g_r;
      wdata = {tag, hd_g, hd_ok};
    end
  end

  always_ff @(posedge clk) begin
    if (we) hdr_mem[waddr] <= wdata;
    if (cmd.dec) rdata_r <= hdr_mem[rd_addr];
  end

  assign used_add  = 14'(used_r) + 14'(aligned_r);
  assign hdr_bytes = 14'(hdrs_r) << $clog2(HEADER_BYTES);
  assign cb_free   = class_bytes[tag[1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r   <= '0;
      head_ok_r   <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.carve_init) clr_idx_r <= '0;
      else if (cmd.clr_step) clr_idx_r <= clr_idx_r + 1'b1;
      if (cmd.carve_init) head_ok_r <= '0;
      if (cmd.carve_step && !carve_done && fits) head_ok_r[ck] <= 1'b1;
      if (cmd.carve_step && carve_done) begin
        used_r <= (hdr_bytes > 14'(USED_MAX)) ? 13'(USED_MAX) : hdr_bytes[12:0];
      end
      if (cmd.commit) begin
        if (in_r.func == FN_ALLOC) begin
          head_ok_r[k_r] <= rdata_r[0];
          used_r <= (used_add > 14'(USED_MAX)) ? 13'(USED_MAX) : used_add[12:0];
        end else if (tag < n_act) begin
          head_ok_r[tag[1:0]] <= 1'b1;
          used_r <= (used_r > 13'(cb_free)) ? used_r - 13'(cb_free) : 13'd0;
        end
      end
      if (cmd.resp) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) in_r <= in_data;
    if (cmd.dec) begin
      res_status_r <= dec_status;
      res_off_r    <= '0;
      res_cls_r    <= '0;
      g_r          <= (in_r.func == FN_ALLOC) ? hd_g : boff[ALIGN_SH +: GRAN_W];
      k_r          <= kfit;
      aligned_r    <= aligned;
    end
    if (cmd.carve_init) begin
      ck_r   <= '0;
      ptr_r  <= '0;
      cc_r   <= '0;
      hdrs_r <= '0;
    end
    if (cmd.carve_step && !carve_done) begin
      if (fits) begin
        head_r[ck] <= ptr_r[ALIGN_SH +: GRAN_W];
        ptr_r      <= pend[12:0];
        cc_r       <= cy[12:0];
        hdrs_r     <= hdrs_r + 1'b1;
      end else begin
        ck_r <= ck_r + 1'b1;
        cc_r <= '0;
      end
    end
    if (cmd.commit) begin
      if (in_r.func == FN_ALLOC) begin
        head_r[k_r] <= rdata_r[GRAN_W:1];
        res_off_r   <= 12'({g_r, {ALIGN_SH{1'b0}}}) + 12'(HEADER_BYTES);
        res_cls_r   <= k_r;
      end else if (tag < n_act) begin
        head_r[tag[1:0]] <= g_r;
        res_cls_r        <= tag[1:0];
      end else begin
        res_status_r <= ST_CORRUPT;
      end
    end
    if (cmd.resp) begin
      out_r.status       <= res_status_r;
      out_r.block_offset <= res_off_r;
      out_r.class_used   <= res_cls_r;
      out_r.used_bytes   <= used_r;
    end
  end

  always_comb begin
    sts            = '0;
    sts.clr_last   = (clr_idx_r == GRAN_W'(GRANULES - 1));
    sts.dec_mem    = dec_mem;
    sts.dec_carve  = dec_carve;
    sts.carve_done = carve_done;
    sts.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* hw/rtl/size_class_pool_allocator.sv */
// ----------------------------------------------------------------------------
// size_class_pool_allocator
// Segregated free-list allocator over a 4 KiB pool with four size classes.
// ----------------------------------------------------------------------------
// One item at a time. After reset a clearing pass writes all 512 header
// entries before the first item is taken. Alloc and free pass through accept,
// decode with the header read, header write-back and response; when decode
// rejects the request, the write-back is skipped. Carve passes through accept
// and decode, a clearing pass over all 512 header entries, a walk that carves
// blocks for each active class in turn, a closing step and the response; a
// carve with bad shares goes from decode straight to the response. A result
// waiting in the output register does not block the next accept.
module size_class_pool_allocator (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  scpa_pkg::in_item_t      in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output scpa_pkg::out_item_t     out_data,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [4:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import scpa_pkg::*;

  logic [3:0][8:0] class_bytes_r;
  logic [3:0][6:0] share_pct_r;
  logic [2:0]      reg_idx;
  logic            in_fire;
  cmd_t            cmd;
  sts_t            sts;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      class_bytes_r <= '0;
      share_pct_r   <= '0;
    end else if (psel && penable && pwrite) begin
      if (!reg_idx[2]) class_bytes_r[reg_idx[1:0]] <= pwdata[8:0];
      else share_pct_r[reg_idx[1:0]] <= pwdata[6:0];
    end
  end

  always_comb begin
    if (!reg_idx[2]) prdata = {23'd0, class_bytes_r[reg_idx[1:0]]};
    else prdata = {25'd0, share_pct_r[reg_idx[1:0]]};
  end

  scpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  scpa_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_data     (in_data),
    .class_bytes (class_bytes_r),
    .share_pct   (share_pct_r),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

`ifndef SYNTHESIS
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("item accepted while another is in flight");

  a_fail_no_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status != ST_OK)) |-> (out_data.block_offset == 12'd0))
    else $error("failed beat carries an offset");

  a_offset_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.block_offset[ALIGN_SH-1:0] == '0))
    else $error("block offset not granule aligned");
`endif

endmodule
